/* sv/wdt_pkg.sv */
// shared types and constants for the windowed duplicate table
// no dependencies
package wdt_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int unsigned KEY_W = 256;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned EXP_W = 34;
  localparam int unsigned ROW_W = 1 + EXP_W + KEY_W;

  localparam logic [TIME_W-1:0] WINDOW_MAX = TIME_W'(36500 * 86400);
  localparam logic [TIME_W-1:0] WINDOW_MIN = TIME_W'(1);

  localparam logic [1:0] OUT_INSERTED  = 2'd0;
  localparam logic [1:0] OUT_DUPLICATE = 2'd1;
  localparam logic [1:0] OUT_FULL      = 2'd2;
  localparam logic [1:0] OUT_NO_ID     = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             clear_we;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
    logic             start;
    logic             insert_we;
  } tbl_ctrl_t;

  typedef struct packed {
    logic match;
    logic found;
  } tbl_stat_t;

endpackage

/* sv/wdt_table.sv */
// entry memory with read-modify-write scan: expiry clearing, match, free slot
// depends on wdt_pkg
module wdt_table (
  input  logic                          clk,
  input  logic                          rst,
  input  wdt_pkg::tbl_ctrl_t            ctrl,
  input  logic [wdt_pkg::KEY_W-1:0]     key,
  input  logic [wdt_pkg::TIME_W-1:0]    now,
  input  logic [wdt_pkg::EXP_W-1:0]     new_exp,
  input  logic                          refresh,
  output wdt_pkg::tbl_stat_t            stat
);

  logic [wdt_pkg::ROW_W-1:0] mem [wdt_pkg::ENTRIES];
  logic [wdt_pkg::ROW_W-1:0] rdata;
  logic                      proc_vld;
  logic [wdt_pkg::IDX_W-1:0] proc_idx;
  logic                      match, match_next;
  logic                      found, found_next;
  logic [wdt_pkg::IDX_W-1:0] free_slot, free_slot_next;

  logic                      row_valid;
  logic [wdt_pkg::EXP_W-1:0] row_exp;
  logic [wdt_pkg::KEY_W-1:0] row_key;
  logic                      live;
  logic                      wb_we;
  logic [wdt_pkg::ROW_W-1:0] wb_data;
  logic                      we;
  logic [wdt_pkg::IDX_W-1:0] waddr;
  logic [wdt_pkg::ROW_W-1:0] wdata;

  assign row_valid = rdata[wdt_pkg::ROW_W-1];
  assign row_exp   = rdata[wdt_pkg::KEY_W +: wdt_pkg::EXP_W];
  assign row_key   = rdata[wdt_pkg::KEY_W-1:0];
  assign live      = row_valid && (row_exp > wdt_pkg::EXP_W'(now));

  always_comb begin
    wb_we          = 1'b0;
    wb_data        = rdata;
    match_next     = match;
    found_next     = found;
    free_slot_next = free_slot;
    if (proc_vld) begin
      if (row_valid && !live) begin
        // expired entry is dropped and counts as free
        wb_we   = 1'b1;
        wb_data = {1'b0, row_exp, row_key};
      end
      if (live) begin
        if (!match && (row_key == key)) begin
          match_next = 1'b1;
          if (refresh) begin
            wb_we   = 1'b1;
            wb_data = {1'b1, new_exp, row_key};
          end
        end
      end else if (!found) begin
        found_next     = 1'b1;
        free_slot_next = proc_idx;
      end
    end
  end

  always_comb begin
    if (ctrl.clear_we) begin
      we    = 1'b1;
      waddr = ctrl.idx;
      wdata = '0;
    end else if (ctrl.insert_we) begin
      we    = 1'b1;
      waddr = free_slot;
      wdata = {1'b1, new_exp, key};
    end else begin
      we    = wb_we;
      waddr = proc_idx;
      wdata = wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[ctrl.idx];
    end
    proc_idx <= ctrl.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld  <= 1'b0;
      match     <= 1'b0;
      found     <= 1'b0;
      free_slot <= '0;
    end else begin
      proc_vld <= ctrl.rd_en;
      if (ctrl.start) begin
        match     <= 1'b0;
        found     <= 1'b0;
        free_slot <= '0;
      end else begin
        match     <= match_next;
        found     <= found_next;
        free_slot <= free_slot_next;
      end
    end
  end

  assign stat.match = match;
  assign stat.found = found;

endmodule

/* sv/windowed_duplicate_table_core.sv */
// top level of the windowed duplicate table: request capture, scan sequencer, result register
// depends on wdt_pkg and wdt_table
//
// usage:
//   request channel req_valid/req_stall carries one check-and-record request per
//   transaction: has_identifier, the 256-bit key in key_word_0..3, current_time,
//   window_length and refresh_on_match.
//   result channel rsp_valid/rsp_stall returns one transaction per request:
//   is_duplicate and outcome (inserted, duplicate, table full, no identifier).
//   a request without identifier is answered in the cycle after acceptance.
//   a request with identifier walks every table entry through the entry memory,
//   one read per cycle, clearing expired entries on the way; it passes through
//   the scan, drain and finish states, and its result is registered on leaving
//   finish while the output register is free. the next request is taken once
//   the sequencer is back in idle.
//   after reset the block clears the memory, one entry per cycle, with req_stall
//   high.
//   a stalled result holds in the output register; a new request is taken only
//   while that register is empty or being drained.
module windowed_duplicate_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          has_identifier,
  input  logic [63:0]                   key_word_0,
  input  logic [63:0]                   key_word_1,
  input  logic [63:0]                   key_word_2,
  input  logic [63:0]                   key_word_3,
  input  logic [wdt_pkg::TIME_W-1:0]    current_time,
  input  logic [wdt_pkg::TIME_W-1:0]    window_length,
  input  logic                          refresh_on_match,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          is_duplicate,
  output logic [1:0]                    outcome
);

  wdt_pkg::state_t           state, state_next;
  logic [wdt_pkg::IDX_W-1:0] cnt;
  logic [wdt_pkg::KEY_W-1:0] key_q;
  logic [wdt_pkg::TIME_W-1:0] now_q;
  logic [wdt_pkg::EXP_W-1:0] new_exp_q;
  logic                      refresh_q;
  logic [wdt_pkg::TIME_W-1:0] win_sat;
  wdt_pkg::tbl_ctrl_t        ctrl;
  wdt_pkg::tbl_stat_t        stat;
  logic                      req_acc;
  logic                      out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != wdt_pkg::ST_IDLE) || !out_free;
  assign req_acc   = req_valid && !req_stall;

  always_comb begin
    if (window_length < wdt_pkg::WINDOW_MIN) begin
      win_sat = wdt_pkg::WINDOW_MIN;
    end else if (window_length > wdt_pkg::WINDOW_MAX) begin
      win_sat = wdt_pkg::WINDOW_MAX;
    end else begin
      win_sat = window_length;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wdt_pkg::ST_CLEAR: begin
        if (cnt == wdt_pkg::LAST_IDX) state_next = wdt_pkg::ST_IDLE;
      end
      wdt_pkg::ST_IDLE: begin
        if (req_acc && has_identifier) state_next = wdt_pkg::ST_SCAN;
      end
      wdt_pkg::ST_SCAN: begin
        if (cnt == wdt_pkg::LAST_IDX) state_next = wdt_pkg::ST_DRAIN;
      end
      wdt_pkg::ST_DRAIN: begin
        state_next = wdt_pkg::ST_FINISH;
      end
      wdt_pkg::ST_FINISH: begin
        if (out_free) state_next = wdt_pkg::ST_IDLE;
      end
      default: state_next = wdt_pkg::ST_CLEAR;
    endcase
  end

  // table control
  always_comb begin
    ctrl = '0;
    ctrl.idx = cnt;
    ctrl.start = req_acc;
    unique case (state)
      wdt_pkg::ST_CLEAR:  ctrl.clear_we = 1'b1;
      wdt_pkg::ST_SCAN:   ctrl.rd_en = 1'b1;
      wdt_pkg::ST_FINISH: ctrl.insert_we = out_free && !stat.match && stat.found;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdt_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == wdt_pkg::ST_CLEAR || state == wdt_pkg::ST_SCAN) begin
        cnt <= (cnt == wdt_pkg::LAST_IDX) ? '0 : cnt + 1'b1;
      end else if (req_acc) begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      key_q     <= {key_word_3, key_word_2, key_word_1, key_word_0};
      now_q     <= current_time;
      new_exp_q <= wdt_pkg::EXP_W'(current_time) + wdt_pkg::EXP_W'(win_sat);
      refresh_q <= refresh_on_match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_acc && !has_identifier) begin
      rsp_valid <= 1'b1;
    end else if (state == wdt_pkg::ST_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && !has_identifier) begin
      is_duplicate <= 1'b0;
      outcome      <= wdt_pkg::OUT_NO_ID;
    end else if (state == wdt_pkg::ST_FINISH && out_free) begin
      is_duplicate <= stat.match;
      if (stat.match) begin
        outcome <= wdt_pkg::OUT_DUPLICATE;
      end else if (stat.found) begin
        outcome <= wdt_pkg::OUT_INSERTED;
      end else begin
        outcome <= wdt_pkg::OUT_FULL;
      end
    end
  end

  wdt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .key     (key_q),
    .now     (now_q),
    .new_exp (new_exp_q),
    .refresh (refresh_q),
    .stat    (stat)
  );

  a_dup_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_duplicate == (outcome == wdt_pkg::OUT_DUPLICATE)))
    else $error("duplicate flag disagrees with outcome");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == wdt_pkg::ST_CLEAR) |-> req_stall)
    else $error("request taken during memory clear");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == wdt_pkg::ST_FINISH ||
      $past(req_valid && !req_stall && !has_identifier)))
    else $error("result without a finished request");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == wdt_pkg::ST_SCAN && cnt == wdt_pkg::LAST_IDX) |=>
      (state == wdt_pkg::ST_DRAIN))
    else $error("scan did not end after last entry");

endmodule
